[design/ftrc_pkg.sv]
// Shared types and constants for the five-tuple rule classifier.
package ftrc_pkg;

    localparam int DEFAULT_RULE_SLOTS = 64;

    // Item operation codes
    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // Rule actions
    localparam logic ACT_ALLOW = 1'b0;
    localparam logic ACT_DENY  = 1'b1;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Protocol classes
    localparam logic [1:0] CLASS_TCP  = 2'd0;
    localparam logic [1:0] CLASS_UDP  = 2'd1;
    localparam logic [1:0] CLASS_ICMP = 2'd2;
    localparam logic [1:0] CLASS_IP   = 2'd3;

    // IP header protocol numbers
    localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;
    localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
    localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  proto;
        logic        action;
        logic [31:0] id;
    } rule_t;

    typedef struct packed {
        logic [1:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
    } key_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

[design/ftrc_rule_mem.sv]
// Rule storage: one write port, one registered read port.
module ftrc_rule_mem
    import ftrc_pkg::*;
#(
    parameter int RULE_SLOTS = DEFAULT_RULE_SLOTS,
    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  rule_t            wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output rule_t            rd_data
);

    rule_t rule_mem [RULE_SLOTS];
    rule_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rule_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= rule_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/ftrc_match.sv]
// Compare unit: checks one stored rule against the packet key.
module ftrc_match
    import ftrc_pkg::*;
(
    input  rule_t rule,
    input  key_t  key,
    output logic  hit
);

    logic class_ok;
    logic src_ok;
    logic dst_ok;
    logic sport_ok;
    logic dport_ok;

    // zero in a rule field is a wildcard; ip-class rules never match
    always_comb begin
        class_ok = (rule.proto == key.proto) && (rule.proto != CLASS_IP);
        src_ok   = (rule.src_addr == 32'd0) || (rule.src_addr == key.src_addr);
        dst_ok   = (rule.dst_addr == 32'd0) || (rule.dst_addr == key.dst_addr);
        sport_ok = (rule.sport == 16'd0) || (rule.sport == key.sport);
        dport_ok = (rule.dport == 16'd0) || (rule.dport == key.dport);
        hit      = class_ok && src_ok && dst_ok && sport_ok && dport_ok;
    end

endmodule

[design/five_tuple_rule_classifier.sv]
// Top level of the five-tuple first-match rule classifier.
//
// Every input transfer gives exactly one result transfer. An add item
// (operation 0) appends a rule at the end of the table, or answers status 1
// when all RULE_SLOTS entries are taken; its result goes from the done state
// into the output register. A classify item (operation 1) maps protocol 17/6/1 to
// udp/tcp/icmp (ports forced to 0 for icmp and unknown protocols) and scans
// the stored rules from newest to oldest, one rule per cycle through the
// single read port of the rule memory and one shared compare unit. The first
// rule that matches on class, addresses and ports decides: deny sets drop,
// allow clears it, and matched_rule_id gives the rule's id. No match means
// accept with matched 0. The scan stops at the first hit or once the oldest
// rule has been compared; unknown protocols and an empty table skip the
// scan and go straight to the done state. The block takes one item at a
// time: s_ready is high only while the sequencer is idle. A finished result
// sits in an output register, so the next item may be taken while the
// result waits for m_ready. The rule memory needs no clearing after reset;
// only entries below the rule count are ever read.
module five_tuple_rule_classifier
    import ftrc_pkg::*;
#(
    parameter int RULE_SLOTS = DEFAULT_RULE_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_rule_id,
    input  logic        s_rule_action,
    input  logic [1:0]  s_rule_proto,
    input  logic [31:0] s_src_addr,
    input  logic [31:0] s_dst_addr,
    input  logic [15:0] s_src_port_num,
    input  logic [15:0] s_dst_port_num,
    input  logic [7:0]  s_ip_protocol,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_drop,
    output logic        m_matched,
    output logic [31:0] m_matched_rule_id,
    output logic        m_status
);

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W = $clog2(RULE_SLOTS + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_m1;
    logic             table_full;
    logic             table_empty;

    logic [IDX_W-1:0] idx_reg;
    key_t             key_reg;
    key_t             key_in;
    logic             class_valid;

    logic             res_drop_reg;
    logic             res_matched_reg;
    logic [31:0]      res_id_reg;
    logic             res_status_reg;

    logic             m_valid_reg;
    logic             m_drop_reg;
    logic             m_matched_reg;
    logic [31:0]      m_id_reg;
    logic             m_status_reg;

    logic             in_xfer;
    logic             out_free;
    logic             load_out;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    rule_t            wr_rule;
    rule_t            rd_rule;
    logic             hit;

    assign in_xfer     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign table_full  = (total_reg == CNT_W'(RULE_SLOTS));
    assign table_empty = (total_reg == '0);
    assign total_m1    = total_reg - CNT_W'(1);

    // Protocol number to class; ports only count for tcp and udp.
    always_comb begin
        key_in.src_addr = s_src_addr;
        key_in.dst_addr = s_dst_addr;
        key_in.sport    = 16'd0;
        key_in.dport    = 16'd0;
        key_in.proto    = CLASS_IP;
        class_valid     = 1'b1;
        if (s_ip_protocol == PROTO_NUM_UDP) begin
            key_in.proto = CLASS_UDP;
            key_in.sport = s_src_port_num;
            key_in.dport = s_dst_port_num;
        end else if (s_ip_protocol == PROTO_NUM_TCP) begin
            key_in.proto = CLASS_TCP;
            key_in.sport = s_src_port_num;
            key_in.dport = s_dst_port_num;
        end else if (s_ip_protocol == PROTO_NUM_ICMP) begin
            key_in.proto = CLASS_ICMP;
        end else begin
            class_valid = 1'b0;
        end
    end

    always_comb begin
        wr_rule.src_addr = s_src_addr;
        wr_rule.dst_addr = s_dst_addr;
        wr_rule.sport    = s_src_port_num;
        wr_rule.dport    = s_dst_port_num;
        wr_rule.proto    = s_rule_proto;
        wr_rule.action   = s_rule_action;
        wr_rule.id       = s_rule_id;
    end

    ftrc_rule_mem #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_rule_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (total_reg[IDX_W-1:0]),
        .wr_data (wr_rule),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_rule)
    );

    ftrc_match u_match (
        .rule (rd_rule),
        .key  (key_reg),
        .hit  (hit)
    );

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_operation == OP_CLASSIFY && class_valid && !table_empty) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (hit || idx_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs. Next read is issued while the current entry is compared.
    always_comb begin
        s_ready  = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = total_m1[IDX_W-1:0];
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                wr_en   = s_valid && (s_operation == OP_ADD) && !table_full;
                rd_en   = s_valid && (s_operation == OP_CLASSIFY) && !table_empty;
            end
            ST_SCAN: begin
                rd_addr = idx_reg - IDX_W'(1);
                rd_en   = !hit && (idx_reg != '0);
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                total_reg <= total_reg + CNT_W'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            key_reg         <= key_in;
            idx_reg         <= total_m1[IDX_W-1:0];
            res_drop_reg    <= ACT_ALLOW;
            res_matched_reg <= 1'b0;
            res_id_reg      <= 32'd0;
            res_status_reg  <= (s_operation == OP_ADD && table_full) ? STATUS_FULL
                                                                     : STATUS_OK;
        end else if (state_reg == ST_SCAN) begin
            idx_reg <= idx_reg - IDX_W'(1);
            if (hit) begin
                res_drop_reg    <= rd_rule.action;
                res_matched_reg <= 1'b1;
                res_id_reg      <= rd_rule.id;
            end
        end
        if (load_out) begin
            m_drop_reg    <= res_drop_reg;
            m_matched_reg <= res_matched_reg;
            m_id_reg      <= res_id_reg;
            m_status_reg  <= res_status_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_drop            = m_drop_reg;
    assign m_matched         = m_matched_reg;
    assign m_matched_rule_id = m_id_reg;
    assign m_status          = m_status_reg;

    // Rule count never runs past the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(RULE_SLOTS))
        else $error("rule count exceeds table size");

    // A stored rule bumps the count by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> total_reg == $past(total_reg) + CNT_W'(1))
        else $error("rule count not advanced after store");

    // Scan ends once the oldest entry has been compared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && idx_reg == '0) |=> state_reg != ST_SCAN)
        else $error("scan ran past oldest rule");

    // A result is only launched from the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result launched outside done state");

    // Refused adds and drops are mutually consistent with the match flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_drop_reg || m_matched_reg) &&
                        (!m_status_reg || !m_matched_reg))
        else $error("inconsistent result flags");

endmodule

[tb/five_tuple_rule_classifier_test.sv]
// Self-checking testbench for the five-tuple first-match rule classifier.
`timescale 1ns / 100ps

module five_tuple_rule_classifier_test;
    import ftrc_pkg::*;

    // Longest stretch with no transfer on either channel before we give up.
    // It covers a full scan of the table plus the random gaps on either side.
    localparam int QUIET_LIMIT  = 2000;
    // Cycles to watch for stray results once everything has come back.
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1750;
    localparam int SLOTS        = DEFAULT_RULE_SLOTS;

    // One result transfer, as the block should present it.
    typedef struct packed {
        logic        drop;
        logic        matched;
        logic [31:0] rule_id;
        logic        status;
    } verdict_t;

    // Tracks the rule table on the side and keeps the verdicts still owed
    // by the block, oldest first.
    class verdict_scoreboard;
        rule_t    rules [SLOTS];
        int       rule_count = 0;
        verdict_t due_verdicts [$];
        int       mismatches = 0;

        static function bit field_hit(logic [31:0] rule_val, logic [31:0] pkt_val);
            return rule_val == 32'h0 || rule_val == pkt_val;
        endfunction

        function int pending();
            return due_verdicts.size();
        endfunction

        // Called on every accepted input transfer.
        function void note_item(logic op, logic [31:0] id, logic act, logic [1:0] proto,
                                logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                logic [15:0] dp, logic [7:0] pnum);
            verdict_t   v;
            rule_t      r;
            logic [1:0] pkt_class;
            bit         known;
            v = '0;
            if (op == OP_ADD) begin
                if (rule_count >= SLOTS) begin
                    v.status = STATUS_FULL;
                end else begin
                    r.src_addr = sa;
                    r.dst_addr = da;
                    r.sport    = sp;
                    r.dport    = dp;
                    r.proto    = proto;
                    r.action   = act;
                    r.id       = id;
                    rules[rule_count] = r;
                    rule_count++;
                end
            end else begin
                known     = 1'b1;
                pkt_class = CLASS_IP;
                case (pnum)
                    PROTO_NUM_UDP: pkt_class = CLASS_UDP;
                    PROTO_NUM_TCP: pkt_class = CLASS_TCP;
                    PROTO_NUM_ICMP: begin
                        pkt_class = CLASS_ICMP;
                        sp = '0;
                        dp = '0;
                    end
                    default: known = 1'b0;
                endcase
                // newest rule first; ip-class rules never hit
                for (int k = rule_count - 1; known && k >= 0 && !v.matched; k--) begin
                    r = rules[k];
                    if (r.proto == pkt_class && r.proto != CLASS_IP &&
                        field_hit(r.src_addr, sa) && field_hit(r.dst_addr, da) &&
                        field_hit({16'h0, r.sport}, {16'h0, sp}) &&
                        field_hit({16'h0, r.dport}, {16'h0, dp})) begin
                        v.matched = 1'b1;
                        v.rule_id = r.id;
                        v.drop    = (r.action == ACT_DENY);
                    end
                end
            end
            due_verdicts.push_back(v);
        endfunction

        // Called on every accepted result transfer.
        function void check_verdict(logic drop, logic matched, logic [31:0] rule_id,
                                    logic status);
            verdict_t v;
            if (due_verdicts.size() == 0) begin
                $display("%0t: result with nothing pending: drop %0d matched %0d id %h status %0d",
                         $time, drop, matched, rule_id, status);
                mismatches++;
                return;
            end
            v = due_verdicts.pop_front();
            if (drop !== v.drop) begin
                $display("%0t: drop expected %0d actual %0d", $time, v.drop, drop);
                mismatches++;
            end
            if (matched !== v.matched) begin
                $display("%0t: matched expected %0d actual %0d", $time, v.matched, matched);
                mismatches++;
            end
            if (rule_id !== v.rule_id) begin
                $display("%0t: matched_rule_id expected %h actual %h",
                         $time, v.rule_id, rule_id);
                mismatches++;
            end
            if (status !== v.status) begin
                $display("%0t: status expected %0d actual %0d", $time, v.status, status);
                mismatches++;
            end
        endfunction
    endclass

    // Clock, reset and block ports. Every input is known from time zero.
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_operation    = OP_ADD;
    logic [31:0] s_rule_id      = '0;
    logic        s_rule_action  = ACT_ALLOW;
    logic [1:0]  s_rule_proto   = CLASS_TCP;
    logic [31:0] s_src_addr     = '0;
    logic [31:0] s_dst_addr     = '0;
    logic [15:0] s_src_port_num = '0;
    logic [15:0] s_dst_port_num = '0;
    logic [7:0]  s_ip_protocol  = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_drop;
    logic        m_matched;
    logic [31:0] m_matched_rule_id;
    logic        m_status;

    verdict_scoreboard sb = new();

    // Toggled now and then so that long runs without any idling occur.
    bit calm_source = 1'b0;
    bit calm_sink   = 1'b0;
    int quiet_cycles = 0;

    five_tuple_rule_classifier uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sends one item: optional idle gap with valid low, then hold valid and
    // payload until the transfer happens. Valid stays high across
    // back-to-back items so it is never dropped and raised in one step.
    task automatic drive_item(logic op, logic [31:0] id, logic act, logic [1:0] proto,
                              logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                              logic [15:0] dp, logic [7:0] pnum);
        int gap;
        if ($urandom_range(0, 99) == 0)
            calm_source = !calm_source;
        gap = calm_source ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_rule_id      <= id;
        s_rule_action  <= act;
        s_rule_proto   <= proto;
        s_src_addr     <= sa;
        s_dst_addr     <= da;
        s_src_port_num <= sp;
        s_dst_port_num <= dp;
        s_ip_protocol  <= pnum;
        // sampled right after the edge, so these are the values the block saw
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sb.note_item(op, id, act, proto, sa, da, sp, dp, pnum);
    endtask

    // Stop sending and wait for every owed result to come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Small pools make rules and packets collide often; wildcards only make
    // sense on the rule side.
    function automatic logic [31:0] pick_addr(bit rule_side);
        logic [31:0] pool [4];
        pool = '{32'h0A00_0001, 32'hC0A8_0101, 32'hFFFF_FFFF, 32'h0000_0001};
        case ($urandom_range(0, 7))
            0, 1:       return rule_side ? 32'h0 : pool[$urandom_range(0, 3)];
            2, 3, 4, 5: return pool[$urandom_range(0, 3)];
            6:          return rule_side ? pool[0] : 32'h0;
            default:    return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_port(bit rule_side);
        logic [15:0] pool [4];
        pool = '{16'd80, 16'd443, 16'hFFFF, 16'd1};
        case ($urandom_range(0, 7))
            0, 1:       return rule_side ? 16'h0 : pool[$urandom_range(0, 3)];
            2, 3, 4, 5: return pool[$urandom_range(0, 3)];
            6:          return rule_side ? pool[1] : 16'h0;
            default:    return 16'($urandom());
        endcase
    endfunction

    // Result side: random stall before each result, then accept it and check.
    initial begin : result_sink
        int stall;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 99) == 0)
                calm_sink = !calm_sink;
            stall = calm_sink ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            sb.check_verdict(m_drop, m_matched, m_matched_rule_id, m_status);
        end
    end

    // Watchdog: a long stretch with no transfer at all means the block hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic        op;
        logic [31:0] id;
        logic        act;
        logic [1:0]  proto;
        logic [7:0]  pnum;
        bit          rule_side;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        // empty table: tcp miss and an unknown protocol
        drive_item(OP_CLASSIFY, 32'hFFFF_FFFF, ACT_DENY, CLASS_IP,
                   32'h0A00_0001, 32'hC0A8_0001, 16'hFFFF, 16'd80, PROTO_NUM_TCP);
        drive_item(OP_CLASSIFY, '0, ACT_ALLOW, CLASS_TCP, '0, '0, '0, '0, 8'd0);
        // exact tcp deny rule with the widest id and port
        drive_item(OP_ADD, 32'hFFFF_FFFF, ACT_DENY, CLASS_TCP,
                   32'h0A00_0001, 32'hC0A8_0001, 16'hFFFF, 16'd80, 8'hFF);
        drive_item(OP_CLASSIFY, '0, ACT_ALLOW, CLASS_TCP,
                   32'h0A00_0001, 32'hC0A8_0001, 16'hFFFF, 16'd80, PROTO_NUM_TCP);
        // one port off: miss
        drive_item(OP_CLASSIFY, '0, ACT_ALLOW, CLASS_TCP,
                   32'h0A00_0001, 32'hC0A8_0001, 16'hFFFF, 16'd81, PROTO_NUM_TCP);
        // all-wildcard tcp allow with id 0, newer, so it shadows the deny
        drive_item(OP_ADD, 32'h0, ACT_ALLOW, CLASS_TCP, '0, '0, '0, '0, PROTO_NUM_TCP);
        drive_item(OP_CLASSIFY, 32'hFFFF_FFFF, ACT_DENY, CLASS_IP,
                   32'h0A00_0001, 32'hC0A8_0001, 16'hFFFF, 16'd80, PROTO_NUM_TCP);
        // udp deny with all-ones addresses and destination port
        drive_item(OP_ADD, 32'h1234_5678, ACT_DENY, CLASS_UDP,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'hFFFF, 8'd0);
        drive_item(OP_CLASSIFY, '0, ACT_ALLOW, CLASS_TCP,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'hFFFF, PROTO_NUM_UDP);
        // same tuple as tcp: class decides, the tcp wildcard hits
        drive_item(OP_CLASSIFY, '0, ACT_ALLOW, CLASS_TCP,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'hFFFF, PROTO_NUM_TCP);
        // icmp rule with a port can never hit, ports of icmp packets are zero
        drive_item(OP_ADD, 32'h8000_0000, ACT_DENY, CLASS_ICMP,
                   32'h0102_0304, '0, 16'h1234, '0, 8'd0);
        drive_item(OP_CLASSIFY, '0, ACT_ALLOW, CLASS_TCP,
                   32'h0102_0304, 32'h0506_0708, 16'h1234, '0, PROTO_NUM_ICMP);
        drive_item(OP_ADD, 32'h0000_0001, ACT_DENY, CLASS_ICMP,
                   32'h0102_0304, '0, '0, '0, 8'd0);
        drive_item(OP_CLASSIFY, '0, ACT_ALLOW, CLASS_TCP,
                   32'h0102_0304, 32'h0506_0708, 16'hFFFF, 16'hFFFF, PROTO_NUM_ICMP);
        // ip-class wildcard deny: stored but never hits anything
        drive_item(OP_ADD, 32'hA5A5_A5A5, ACT_DENY, CLASS_IP, '0, '0, '0, '0, 8'd0);
        drive_item(OP_CLASSIFY, '0, ACT_ALLOW, CLASS_IP, '0, '0, '0, '0, 8'd0);
        drive_item(OP_CLASSIFY, 32'hFFFF_FFFF, ACT_DENY, CLASS_IP,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        drive_item(OP_CLASSIFY, '0, ACT_ALLOW, CLASS_TCP,
                   32'h0102_0304, '0, '0, '0, 8'd4);
        // zero tuple on tcp: only the wildcard rule (id 0) fits
        drive_item(OP_CLASSIFY, 32'hFFFF_FFFF, ACT_DENY, CLASS_IP,
                   '0, '0, '0, '0, PROTO_NUM_TCP);

        // sender holds off until the block has answered everything
        wait_for_results();

        // ---- random part ----
        // Mostly classifies against pooled tuples; about one add in twelve
        // fills the table part way through, after which adds are refused.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                wait_for_results();
            op        = ($urandom_range(0, 11) == 0) ? OP_ADD : OP_CLASSIFY;
            rule_side = (op == OP_ADD);
            id        = $urandom();
            act       = 1'($urandom_range(0, 1));
            proto     = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1, 2: pnum = PROTO_NUM_TCP;
                3, 4, 5: pnum = PROTO_NUM_UDP;
                6, 7:    pnum = PROTO_NUM_ICMP;
                default: pnum = 8'($urandom_range(0, 255));
            endcase
            drive_item(op, id, act, proto, pick_addr(rule_side), pick_addr(rule_side),
                       pick_port(rule_side), pick_port(rule_side), pnum);
        end

        wait_for_results();
        // keep watching for a result nobody asked for
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[five_tuple_rule_classifier.f]
design/ftrc_pkg.sv
design/ftrc_rule_mem.sv
design/ftrc_match.sv
design/five_tuple_rule_classifier.sv
tb/five_tuple_rule_classifier_test.sv
